// ===== hdl/pwfsk_pkg.sv =====
// Shared types and constants of the pulse-width keyed tone frame sender.
// Used by every module of the block but the port checker; depends on nothing.
package pwfsk_pkg;

  // Operation codes carried in the input word's tuser
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CHAR   = 2'd1,
    OP_DIGITS = 2'd2,
    OP_STATUS = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_HEADER_MARK  = 3'd0;
  localparam logic [2:0] CFG_ONE_MARK     = 3'd1;
  localparam logic [2:0] CFG_ZERO_MARK    = 3'd2;
  localparam logic [2:0] CFG_TRAILER_MARK = 3'd3;
  localparam logic [2:0] CFG_GAP          = 3'd4;
  localparam logic [2:0] CFG_MARK_LEVEL   = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned DacW     = 12;

  typedef struct packed {
    logic [TicksW-1:0] header_mark;
    logic [TicksW-1:0] one_mark;
    logic [TicksW-1:0] zero_mark;
    logic [TicksW-1:0] trailer_mark;
    logic [TicksW-1:0] gap;
    logic [DacW-1:0]   mark_level;
  } cfg_t;

  // One queued request
  typedef struct packed {
    logic        ends;
    logic        starts;
    logic        digits;
    logic [15:0] data;
  } req_t;

  // Queue control from the engine
  typedef struct packed {
    logic push;
    logic pop;
    req_t wdata;
  } fifo_ctl_t;

  // Queue status towards the engine
  typedef struct packed {
    logic full;
    logic head_vld;
  } fifo_stat_t;

  // One result word, tone_mark in the lowest bit
  typedef struct packed {
    logic            accepted;
    logic            busy_res;
    logic [DacW-1:0] dac_code;
    logic            tone_mark;
  } res_t;

endpackage

// ===== hdl/pwfsk_fifo.sv =====
// Request queue: a head register in front of a small memory.
// Depends on pwfsk_pkg.
module pwfsk_fifo #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pwfsk_pkg::fifo_ctl_t   ctl_i,
  output pwfsk_pkg::fifo_stat_t  stat_o,
  output pwfsk_pkg::req_t        head_o
);
  import pwfsk_pkg::*;

  localparam int unsigned MemDepth = (QUEUE_DEPTH > 1) ? QUEUE_DEPTH - 1 : 1;
  localparam int unsigned PtrW     = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned CntW     = $clog2(QUEUE_DEPTH + 1);

  req_t            mem_q [MemDepth];
  req_t            head_q;
  logic            head_vld_q;
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            mem_wr, mem_rd;

  // spill into memory only behind a valid head; refill head from memory on pop
  assign mem_wr = ctl_i.push && head_vld_q;
  assign mem_rd = ctl_i.pop && (cnt_q != '0);

  assign stat_o.head_vld = head_vld_q;
  assign stat_o.full     = head_vld_q && (cnt_q == CntW'(QUEUE_DEPTH - 1));
  assign head_o          = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      wr_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= '0;
    end else begin
      if (ctl_i.push && !head_vld_q) begin
        head_vld_q <= 1'b1;
      end else if (ctl_i.pop && !mem_rd) begin
        head_vld_q <= 1'b0;
      end
      if (mem_wr) begin
        wr_q  <= (wr_q == PtrW'(MemDepth - 1)) ? '0 : wr_q + 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      if (mem_rd) begin
        rd_q  <= (rd_q == PtrW'(MemDepth - 1)) ? '0 : rd_q + 1'b1;
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[wr_q] <= ctl_i.wdata;
    end
    if (ctl_i.push && !head_vld_q) begin
      head_q <= ctl_i.wdata;
    end else if (mem_rd) begin
      head_q <= mem_q[rd_q];
    end
  end

endmodule

// ===== hdl/pwfsk_engine.sv =====
// Frame engine: configuration registers, symbol sequencer and result logic.
// Depends on pwfsk_pkg; drives the request queue.
module pwfsk_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwfsk_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pwfsk_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          acc_i,
  input  pwfsk_pkg::op_e                op_i,
  input  logic [7:0]                    char_value_i,
  input  logic [15:0]                   digit_word_i,
  input  logic                          starts_frame_i,
  input  logic                          ends_frame_i,
  input  pwfsk_pkg::fifo_stat_t         fifo_stat_i,
  input  pwfsk_pkg::req_t               head_i,
  output pwfsk_pkg::fifo_ctl_t          fifo_ctl_o,
  output pwfsk_pkg::res_t               res_o
);
  import pwfsk_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_HEADER     = 3'd1,
    PH_DATA       = 3'd2,
    PH_PARITY     = 3'd3,
    PH_PARITY_INV = 3'd4,
    PH_TRAILER    = 3'd5
  } phase_e;

  cfg_t              cfg_q;
  req_t              cur_q, cur_d;
  phase_e            phase_q, phase_d;
  logic [3:0]        bit_q, bit_d;
  logic              mark_q, mark_d;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic              par_q, par_d;
  logic              tone;

  function automatic logic [TicksW-1:0] nz(input logic [TicksW-1:0] v);
    return (v == '0) ? TicksW'(1) : v;
  endfunction

  function automatic logic [TicksW-1:0] mark_len(input phase_e ph, input req_t rq,
                                                  input logic [3:0] bp, input logic par,
                                                  input cfg_t c);
    logic sym;
    sym = 1'b0;
    unique case (ph)
      PH_HEADER:     return nz(c.header_mark);
      PH_TRAILER:    return nz(c.trailer_mark);
      PH_PARITY:     sym = par;
      PH_PARITY_INV: sym = ~par;
      default:       sym = rq.data[(rq.digits ? 4'd15 : 4'd7) - bp];
    endcase
    return sym ? nz(c.one_mark) : nz(c.zero_mark);
  endfunction

  always_comb begin
    logic [TicksW-1:0] dec;
    dec        = '0;
    cur_d      = cur_q;
    phase_d    = phase_q;
    bit_d      = bit_q;
    mark_d     = mark_q;
    ticks_d    = ticks_q;
    par_d      = par_q;
    fifo_ctl_o = '0;
    tone       = mark_q;
    res_o      = '0;

    if (acc_i) begin
      unique case (op_i)
        OP_CHAR, OP_DIGITS: begin
          if (!fifo_stat_i.full) begin
            fifo_ctl_o.push = 1'b1;
            res_o.accepted  = 1'b1;
          end
          if (op_i == OP_CHAR) begin
            fifo_ctl_o.wdata = '{ends: ends_frame_i, starts: starts_frame_i,
                                 digits: 1'b0, data: {8'h00, char_value_i}};
          end else begin
            fifo_ctl_o.wdata = '{ends: 1'b0, starts: 1'b0, digits: 1'b1,
                                 data: digit_word_i};
          end
        end
        OP_TICK: begin
          // pop and open the first symbol in this very tick
          if (phase_q == PH_IDLE && fifo_stat_i.head_vld) begin
            fifo_ctl_o.pop = 1'b1;
            cur_d   = head_i;
            bit_d   = '0;
            par_d   = head_i.digits &
                      (head_i.data[12] ^ head_i.data[8] ^ head_i.data[4] ^ head_i.data[0]);
            phase_d = (head_i.digits || head_i.starts) ? PH_HEADER : PH_DATA;
            mark_d  = 1'b1;
            ticks_d = mark_len(phase_d, head_i, 4'd0, par_d, cfg_q);
          end
          tone = mark_d;
          if (phase_d != PH_IDLE) begin
            dec = (ticks_d != '0) ? ticks_d - 1'b1 : '0;
            if (dec != '0) begin
              ticks_d = dec;
            end else if (mark_d) begin
              mark_d  = 1'b0;
              ticks_d = nz(cfg_q.gap);
            end else begin
              unique case (phase_q)
                PH_HEADER: begin
                  phase_d = PH_DATA;
                  bit_d   = '0;
                end
                PH_DATA: begin
                  if (bit_q == (cur_q.digits ? 4'd15 : 4'd7)) begin
                    bit_d = '0;
                    if (cur_q.digits) begin
                      phase_d = PH_PARITY;
                    end else if (cur_q.ends) begin
                      phase_d = PH_TRAILER;
                    end else begin
                      phase_d = PH_IDLE;
                    end
                  end else begin
                    bit_d = bit_q + 1'b1;
                  end
                end
                PH_PARITY:     phase_d = PH_PARITY_INV;
                PH_PARITY_INV: phase_d = PH_TRAILER;
                default:       phase_d = PH_IDLE;
              endcase
              if (phase_d == PH_IDLE) begin
                mark_d  = 1'b0;
                ticks_d = '0;
              end else begin
                mark_d  = 1'b1;
                ticks_d = mark_len(phase_d, cur_q, bit_d, par_q, cfg_q);
              end
            end
          end
        end
        default: ;
      endcase
    end

    res_o.tone_mark = tone;
    res_o.dac_code  = tone ? cfg_q.mark_level : '0;
    res_o.busy_res  = (phase_d != PH_IDLE) || fifo_stat_i.head_vld || fifo_ctl_o.push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '{header_mark: 16'd30, one_mark: 16'd20, zero_mark: 16'd10,
                   trailer_mark: 16'd50, gap: 16'd5, mark_level: 12'd1240};
      cur_q   <= '0;
      phase_q <= PH_IDLE;
      bit_q   <= '0;
      mark_q  <= 1'b0;
      ticks_q <= '0;
      par_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HEADER_MARK:  cfg_q.header_mark  <= cfg_data_i;
          CFG_ONE_MARK:     cfg_q.one_mark     <= cfg_data_i;
          CFG_ZERO_MARK:    cfg_q.zero_mark    <= cfg_data_i;
          CFG_TRAILER_MARK: cfg_q.trailer_mark <= cfg_data_i;
          CFG_GAP:          cfg_q.gap          <= cfg_data_i;
          CFG_MARK_LEVEL:   cfg_q.mark_level   <= cfg_data_i[DacW-1:0];
          default: ;
        endcase
      end
      cur_q   <= cur_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      mark_q  <= mark_d;
      ticks_q <= ticks_d;
      par_q   <= par_d;
    end
  end

endmodule

// ===== hdl/pwfsk_skid.sv =====
// Output stage: result register plus one skid entry so that the input side
// keeps moving while a result waits. Depends on pwfsk_pkg.
module pwfsk_skid (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pwfsk_pkg::res_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pwfsk_pkg::res_t out_data_o
);
  import pwfsk_pkg::*;

  logic out_vld_q, skid_vld_q;
  res_t out_q, skid_q;
  logic pop, push;

  assign in_ready_o  = !skid_vld_q;
  assign push        = in_valid_i && !skid_vld_q;
  assign pop         = out_vld_q && out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !pop) begin
        skid_q <= in_data_i;
      end else begin
        out_q <= in_data_i;
      end
    end
  end

endmodule

// ===== hdl/pulse_width_fsk_frame_sender_top.sv =====
// Top level of the pulse-width keyed tone frame sender.
// Depends on pwfsk_pkg, pwfsk_fifo, pwfsk_engine and pwfsk_skid.
//
// Usage:
//   Input words arrive on s_axis: tuser carries the operation (tick, push
//   character, push four-digit word, status) and starts_frame, tlast carries
//   ends_frame, tdata carries the character and the digit word. Pushes go
//   into a request queue of QUEUE_DEPTH entries; a push into a full queue is
//   dropped and reported with accepted low. Each tick advances the symbol
//   timer by one and reports the tone of that tick.
//   Every input word yields exactly one result word on m_axis: tone_mark,
//   dac_code, busy_res and accepted.
//   A result is registered in the output stage before it is on m_axis.
//   Throughput: one word per cycle while s_axis_tready is high; all per-word
//   work is one engine pass from its state registers into the output stage.
//   Stall: a two-entry output stage (result register plus skid) keeps
//   s_axis_tready high while one result waits; it drops only when both
//   entries hold results the receiver has not taken.
//   Reset: the queue empties, the sequencer goes idle on space tone, and all
//   timing registers return to their defaults.
//   Configuration: write cfg_data_i to register cfg_idx_i while the block is
//   idle; unknown indexes are ignored.
module pulse_width_fsk_frame_sender_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [pwfsk_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pwfsk_pkg::CfgDataW-1:0] cfg_data_i,
  // request / tick stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // char_value[7:0], digit_word[23:8]
  input  logic [2:0]                     s_axis_tuser,  // operation[1:0], starts_frame[2]
  input  logic                           s_axis_tlast,  // ends_frame
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata   // tone_mark[0], dac_code[12:1],
                                                        // busy_res[13], accepted[14], zero[15]
);
  import pwfsk_pkg::*;

  logic       acc;
  fifo_ctl_t  fifo_ctl;
  fifo_stat_t fifo_stat;
  req_t       head;
  res_t       res, res_out;

  // an input word moves whenever the output stage has room
  assign acc = s_axis_tvalid && s_axis_tready;

  pwfsk_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fifo_ctl),
    .stat_o (fifo_stat),
    .head_o (head)
  );

  pwfsk_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .acc_i          (acc),
    .op_i           (op_e'(s_axis_tuser[1:0])),
    .char_value_i   (s_axis_tdata[7:0]),
    .digit_word_i   (s_axis_tdata[23:8]),
    .starts_frame_i (s_axis_tuser[2]),
    .ends_frame_i   (s_axis_tlast),
    .fifo_stat_i    (fifo_stat),
    .head_i         (head),
    .fifo_ctl_o     (fifo_ctl),
    .res_o          (res)
  );

  // hold results here while the receiver stalls
  pwfsk_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res_out)
  );

  // pad the result word to whole bytes
  assign m_axis_tdata = {1'b0, res_out};

endmodule

// ===== hdl/pwfsk_checker.sv =====
// Port-level checks of the frame sender, bound to the top level.
// Depends only on the top level's ports.
module pwfsk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // with no result pending the skid entry must be empty
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // DAC is silent on space tone
  a_dac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[12:1] == 12'd0)
    else $error("dac code driven during space");

  // mark tone or a queued push both leave the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[14]) |-> m_axis_tdata[13])
    else $error("busy low with mark tone or accepted push");

endmodule

bind pulse_width_fsk_frame_sender_top pwfsk_checker u_chk (.*);

// ===== tb/sv/pwfsk_frame_checker.sv =====
// Checker for the pulse-width keyed tone frame sender: tracks the frame
// sequencer and request queue, predicts the result word for each input word
// and compares it field by field. Depends on pwfsk_pkg.
module pwfsk_frame_checker #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pwfsk_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pwfsk_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           s_valid_i,
  input  logic                           s_ready_i,
  input  logic [23:0]                    s_data_i,   // char_value[7:0], digit_word[23:8]
  input  logic [2:0]                     s_user_i,   // operation[1:0], starts_frame[2]
  input  logic                           s_last_i,   // ends_frame
  input  logic                           m_valid_i,
  input  logic                           m_ready_i,
  input  logic [15:0]                    m_data_i,   // tone_mark, dac_code, busy_res, accepted
  output int                             pending_o,
  output int                             fails_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pwfsk_pkg::*;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_LEAD,
    FR_BITS,
    FR_PAR,
    FR_NPAR,
    FR_TAIL
  } frame_e;

  cfg_t        regs;
  req_t        req_fifo[$];
  req_t        cur;
  frame_e      frame;
  logic [4:0]  bit_idx;
  logic        mark_on;
  logic [15:0] left;
  logic        par;
  res_t        tone_words_due[$];
  int          fails;

  function automatic logic [15:0] at_least_1(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [15:0] mark_len();
    logic b;
    int   pos;
    case (frame)
      FR_LEAD: return at_least_1(regs.header_mark);
      FR_TAIL: return at_least_1(regs.trailer_mark);
      FR_PAR:  b = par;
      FR_NPAR: b = ~par;
      default: begin
        pos = ((cur.digits ? 16 : 8) - 1 - int'(bit_idx[3:0])) & 15;
        b   = cur.data[pos];
      end
    endcase
    return at_least_1(b ? regs.one_mark : regs.zero_mark);
  endfunction

  task automatic open_mark();
    mark_on = 1'b1;
    left    = mark_len();
  endtask

  task automatic next_frame_symbol();
    case (frame)
      FR_LEAD: begin
        frame   = FR_BITS;
        bit_idx = '0;
      end
      FR_BITS: begin
        bit_idx++;
        if (bit_idx >= (cur.digits ? 5'd16 : 5'd8)) begin
          bit_idx = '0;
          if (cur.digits)    frame = FR_PAR;
          else if (cur.ends) frame = FR_TAIL;
          else               frame = FR_IDLE;
        end
      end
      FR_PAR:  frame = FR_NPAR;
      FR_NPAR: frame = FR_TAIL;
      default: frame = FR_IDLE;
    endcase
    if (frame == FR_IDLE) begin
      mark_on = 1'b0;
      left    = '0;
    end else begin
      open_mark();
    end
  endtask

  task automatic take_request();
    cur     = req_fifo.pop_front();
    bit_idx = '0;
    if (cur.digits) begin
      // parity of the digit sum is the xor of each digit's low bit
      par   = cur.data[0] ^ cur.data[4] ^ cur.data[8] ^ cur.data[12];
      frame = FR_LEAD;
    end else begin
      par   = 1'b0;
      frame = cur.starts ? FR_LEAD : FR_BITS;
    end
    open_mark();
  endtask

  task automatic predict_tone(output res_t r);
    op_e  op;
    req_t rq;
    logic tone;
    logic took;
    op   = op_e'(s_user_i[1:0]);
    took = 1'b0;
    case (op)
      OP_CHAR, OP_DIGITS: begin
        if (req_fifo.size() < QUEUE_DEPTH) begin
          rq = '0;
          if (op == OP_CHAR) begin
            rq.data   = {8'h00, s_data_i[7:0]};
            rq.starts = s_user_i[2];
            rq.ends   = s_last_i;
          end else begin
            rq.data   = s_data_i[23:8];
            rq.digits = 1'b1;
          end
          req_fifo.push_back(rq);
          took = 1'b1;
        end
        tone = mark_on;
      end
      OP_TICK: begin
        if (frame == FR_IDLE && req_fifo.size() > 0) take_request();
        tone = mark_on;
        if (frame != FR_IDLE) begin
          if (left > 0) left--;
          if (left == 0) begin
            if (mark_on) begin
              mark_on = 1'b0;
              left    = at_least_1(regs.gap);
            end else begin
              next_frame_symbol();
            end
          end
        end
      end
      default: tone = mark_on;
    endcase
    r.tone_mark = tone;
    r.dac_code  = tone ? regs.mark_level : '0;
    r.busy_res  = (frame != FR_IDLE) || (req_fifo.size() > 0);
    r.accepted  = took;
  endtask

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      regs = '{header_mark: 16'd30, one_mark: 16'd20, zero_mark: 16'd10,
               trailer_mark: 16'd50, gap: 16'd5, mark_level: 12'd1240};
      req_fifo.delete();
      tone_words_due.delete();
      cur     = '0;
      frame   = FR_IDLE;
      bit_idx = '0;
      mark_on = 1'b0;
      left    = '0;
      par     = 1'b0;
      fails   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEADER_MARK:  regs.header_mark  = cfg_data_i;
          CFG_ONE_MARK:     regs.one_mark     = cfg_data_i;
          CFG_ZERO_MARK:    regs.zero_mark    = cfg_data_i;
          CFG_TRAILER_MARK: regs.trailer_mark = cfg_data_i;
          CFG_GAP:          regs.gap          = cfg_data_i;
          CFG_MARK_LEVEL:   regs.mark_level   = cfg_data_i[DacW-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        predict_tone(want);
        tone_words_due.push_back(want);
      end
      if (m_valid_i && m_ready_i) begin
        got = res_t'(m_data_i[14:0]);
        if (tone_words_due.size() == 0) begin
          $error("result word %h with no input word outstanding", m_data_i);
          fails++;
        end else begin
          want = tone_words_due.pop_front();
          compare_field("tone_mark", 16'(want.tone_mark), 16'(got.tone_mark));
          compare_field("dac_code", 16'(want.dac_code), 16'(got.dac_code));
          compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
          compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
        end
      end
    end
    pending_o <= tone_words_due.size();
    fails_o   <= fails;
  end

endmodule

// ===== tb/sv/pulse_width_fsk_frame_sender_top_test.sv =====
// Testbench top for the pulse-width keyed tone frame sender: drives request
// and tick words plus register writes, and gives the verdict.
// Depends on pwfsk_pkg, pwfsk_frame_checker and the block's RTL.
module pulse_width_fsk_frame_sender_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pwfsk_pkg::*;

  localparam int unsigned QDepth     = 4;
  localparam int unsigned PhaseWords = 105;
  localparam int unsigned Phases     = 6;
  localparam int unsigned LongHold   = 60;
  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;   // char_value[7:0], digit_word[23:8]
  logic [2:0]          s_axis_tuser;   // operation[1:0], starts_frame[2]
  logic                s_axis_tlast;   // ends_frame
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;   // tone_mark[0], dac_code[12:1], busy_res[13],
                                       // accepted[14], zero[15]

  int pending;
  int fails;

  // calm: no idling on either side; stall_kick: ask the receiver for one long hold
  bit calm        = 1'b0;
  bit stall_kick  = 1'b0;
  bit stall_taken = 1'b0;
  int hold_cycles = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  pulse_width_fsk_frame_sender_top #(
    .QUEUE_DEPTH(QDepth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pwfsk_frame_checker #(
    .QUEUE_DEPTH(QDepth)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .s_last_i   (s_axis_tlast),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .pending_o  (pending),
    .fails_o    (fails)
  );

  // Receiver: drop tready at random, hold it low for a long stretch once when
  // asked, and keep it high throughout a calm stretch.
  always @(posedge clk_i) begin
    if (stall_kick && !stall_taken) begin
      stall_taken = 1'b1;
      hold_cycles = LongHold;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 28);
    end
  end

  // Offer one word and hold it until the block takes it. Idle before it now and
  // then, unless in a calm stretch. Valid stays high between back-to-back words
  // so it is never lowered and raised in one step.
  task automatic send_word(input op_e op, input logic [7:0] ch, input logic [15:0] dw,
                           input logic sf, input logic ef);
    if (!calm && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dw, ch};
    s_axis_tuser  <= {sf, op};
    s_axis_tlast  <= ef;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Mostly ticks so that frames run to their end, with pushes often enough to
  // fill the queue now and then; all data bits random whatever the operation.
  task automatic send_random_word();
    int  r;
    op_e op;
    r = $urandom_range(99);
    if (r < 3)       op = OP_STATUS;
    else if (r < 17) op = OP_CHAR;
    else if (r < 23) op = OP_DIGITS;
    else             op = OP_TICK;
    send_word(op, 8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Stop offering and hold until every result word has come back.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Write all six registers back to back, then drop the write enable.
  task automatic load_timing(input logic [15:0] hdr, input logic [15:0] one,
                             input logic [15:0] zero, input logic [15:0] trl,
                             input logic [15:0] gap, input logic [11:0] level);
    write_reg(CFG_HEADER_MARK, hdr);
    write_reg(CFG_ONE_MARK, one);
    write_reg(CFG_ZERO_MARK, zero);
    write_reg(CFG_TRAILER_MARK, trl);
    write_reg(CFG_GAP, gap);
    write_reg(CFG_MARK_LEVEL, {4'h0, level});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: status and tick while idle, field extremes for both push
    // kinds, then pushes into a full queue, then ticks at reset timing.
    send_word(OP_STATUS, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    send_word(OP_TICK, 8'h00, 16'h0000, 1'b0, 1'b0);
    send_word(OP_CHAR, 8'hFF, 16'h0000, 1'b1, 1'b1);
    send_word(OP_CHAR, 8'h00, 16'hFFFF, 1'b0, 1'b0);
    send_word(OP_DIGITS, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    send_word(OP_DIGITS, 8'h00, 16'h0000, 1'b0, 1'b0);
    send_word(OP_CHAR, 8'h80, 16'h1234, 1'b1, 1'b0);
    send_word(OP_DIGITS, 8'h5A, 16'h9876, 1'b0, 1'b1);
    send_word(OP_STATUS, 8'h00, 16'h0000, 1'b0, 1'b0);
    repeat (14) send_word(OP_TICK, 8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
    send_word(OP_STATUS, 8'h00, 16'h0000, 1'b0, 1'b0);

    // Random phases, each under its own timing. Frames run on across phase
    // boundaries, so new durations also land in the middle of a frame.
    for (int p = 0; p < Phases; p++) begin
      wait_results_drained();
      case (p)
        0: load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 12'd0);
        1: begin
          write_reg(CfgUnused, 16'hFFFF);
          load_timing(16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)),
                      16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)),
                      16'($urandom_range(4, 1)), 12'($urandom));
          calm <= 1'b1;
        end
        // zero durations behave as one tick
        2: load_timing(16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 12'($urandom));
        3: begin
          load_timing(16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)),
                      16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)),
                      16'($urandom_range(6, 1)), 12'hFFF);
          stall_kick <= 1'b1;
        end
        4: load_timing(16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                       16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                       16'($urandom_range(8, 1)), 12'($urandom));
        default: load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
      endcase
      for (int i = 0; i < PhaseWords; i++) begin
        // pause the sender once until every result word has come back
        if (p == 4 && i == PhaseWords / 2) wait_results_drained();
        send_random_word();
      end
      calm <= 1'b0;
    end

    wait_results_drained();
    repeat (4) @(posedge clk_i);
    if (fails == 0) begin
      $display("[pulse_width_fsk_frame_sender_top] OK");
    end else begin
      $display("[pulse_width_fsk_frame_sender_top] ERROR");
    end
    $finish;
  end

  // Run-time limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("[pulse_width_fsk_frame_sender_top] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pwfsk_pkg.sv
hdl/pwfsk_fifo.sv
hdl/pwfsk_engine.sv
hdl/pwfsk_skid.sv
hdl/pulse_width_fsk_frame_sender_top.sv
hdl/pwfsk_checker.sv
tb/sv/pwfsk_frame_checker.sv
tb/sv/pulse_width_fsk_frame_sender_top_test.sv
